@@ rtl/core/grfe_pkg.sv @@
`timescale 1ns / 1ps

package grfe_pkg;

  // fixed field widths of the item and result beats
  localparam int ACTION_W = 2;
  localparam int ADDR_W   = 13;
  localparam int VALUE_W  = 14;
  localparam int NODE_W   = 10;
  localparam int DEG_W    = 10;
  localparam int END_W    = 14;
  localparam int CENTRE_W = 19;
  localparam int TRI_W    = 19;
  localparam int COUNT_W  = 11;
  localparam int PTR_W    = 14;
  localparam int ROW_W    = 10;

  localparam int MAX_NODES_DEF    = 1024;
  localparam int MAX_NONZEROS_DEF = 8192;

  localparam logic [COUNT_W-1:0] NODE_COUNT_RST = 11'd1;

  localparam logic [ACTION_W-1:0] ACT_WR_PTR = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_WR_ROW = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_QUERY  = 2'd2;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [ADDR_W-1:0]   address;
    logic [VALUE_W-1:0]  value;
  } grfe_in_t;

  typedef struct packed {
    logic [NODE_W-1:0]   node;
    logic [DEG_W-1:0]    degree;
    logic [END_W-1:0]    paths_as_end;
    logic [CENTRE_W-1:0] paths_as_centre;
    logic [TRI_W-1:0]    triangles;
    logic                bad_query;
  } grfe_out_t;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_ACCEPT,
    CMD_OWN_LO_RD,
    CMD_OWN_HI_RD,
    CMD_OWN_SET,
    CMD_ROW_RD,
    CMD_NB_LO_RD,
    CMD_NB_HI_RD,
    CMD_NB_SET,
    CMD_NEXT_NB,
    CMD_MERGE_RD,
    CMD_MERGE_STEP,
    CMD_CENTRE,
    CMD_OUTPUT
  } grfe_cmd_t;

  typedef struct packed {
    logic query_bad;
    logic own_done;
    logic nb_out;
    logic merge_done;
  } grfe_status_t;

endpackage

@@ rtl/core/graphlet_raw_frequency_engine.sv @@
`timescale 1ns / 1ps

// graph is loaded through the item channel: action 0 writes a column pointer,
// action 1 writes a row index, action 2 queries a node, action 3 does nothing.
// an item is taken when start is high and busy is low; writes leave busy low,
// so loads can stream at one beat per cycle.
// a query raises busy and returns one result beat on out_valid/out_data,
// valid for exactly one cycle; the receiver cannot stall it.
// a query reads the node's own list bounds, then takes each neighbour in turn:
// one past the node count is skipped, any other has its list bounds read and
// its list merged with the node's own; the merge steps of a neighbour are at
// most its degree plus the node's degree. the walk is set by the one pointer
// read port and the two-port row index memory, each with a registered read.
// a query at or past min(node_count, MAX_NODES) gets zero counts, bad_query set.
// node_count is written on the cfg channel (cfg_ready is always high); the user
// must write it only while no query is in flight; the block does not enforce
// this. reset clears the controller and sets node_count to 1; the graph stores
// are not cleared and must be loaded before they are queried.
module graphlet_raw_frequency_engine #(
  parameter int MAX_NODES    = grfe_pkg::MAX_NODES_DEF,
  parameter int MAX_NONZEROS = grfe_pkg::MAX_NONZEROS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  grfe_pkg::grfe_in_t             in_data,
  output logic                           out_valid,
  output grfe_pkg::grfe_out_t            out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [grfe_pkg::COUNT_W-1:0]   cfg_data
);
  import grfe_pkg::*;

  grfe_cmd_t    cmd;
  grfe_status_t status;

  grfe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_action (in_data.action),
    .busy      (busy),
    .status    (status),
    .cmd       (cmd),
    .out_valid (out_valid)
  );

  grfe_datapath #(
    .MAX_NODES    (MAX_NODES),
    .MAX_NONZEROS (MAX_NONZEROS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .out_data  (out_data)
  );

endmodule

@@ rtl/core/grfe_datapath.sv @@
`timescale 1ns / 1ps

module grfe_datapath #(
  parameter int MAX_NODES    = grfe_pkg::MAX_NODES_DEF,
  parameter int MAX_NONZEROS = grfe_pkg::MAX_NONZEROS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  grfe_pkg::grfe_in_t             in_data,
  input  grfe_pkg::grfe_cmd_t            cmd,
  output grfe_pkg::grfe_status_t         status,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [grfe_pkg::COUNT_W-1:0]   cfg_data,
  output grfe_pkg::grfe_out_t            out_data
);
  import grfe_pkg::*;

  localparam int PA      = $clog2(MAX_NODES + 1);
  localparam int NZ_BITS = $clog2(MAX_NONZEROS + 1);
  localparam int NZ_AW   = $clog2(MAX_NONZEROS);
  localparam int PW      = (NZ_BITS > PTR_W) ? NZ_BITS : PTR_W;
  localparam int NW      = (PA > ADDR_W) ? PA : ADDR_W;
  localparam int SW      = 2 * PW;

  function automatic logic [PW-1:0] clamp_ptr(input logic [PTR_W-1:0] p);
    logic [PW-1:0] w;
    w = PW'(p);
    clamp_ptr = (w > PW'(MAX_NONZEROS)) ? PW'(MAX_NONZEROS) : w;
  endfunction

  logic [PTR_W-1:0] ptr_mem [0:MAX_NODES];
  logic [ROW_W-1:0] row_mem [0:MAX_NONZEROS-1];

  logic [COUNT_W-1:0] node_count_r;
  logic [PTR_W-1:0]   ptr_rd_r;
  logic [ROW_W-1:0]   row_a_r;
  logic [ROW_W-1:0]   row_b_r;
  logic [NW-1:0]      node_r;
  logic               bad_r;
  logic [PW-1:0]      lo_r;
  logic [PW-1:0]      hi_r;
  logic [PW-1:0]      deg_r;
  logic [PW-1:0]      p_r;
  logic [ROW_W-1:0]   nb_r;
  logic [PW-1:0]      nlo_r;
  logic [PW-1:0]      nhi_r;
  logic [PW-1:0]      q_r;
  logic [PW-1:0]      x_r;
  logic [SW-1:0]      nsum_r;
  logic [SW-1:0]      tri_r;
  logic [SW-1:0]      prod_r;
  grfe_out_t          out_r;

  logic [NW-1:0]      active;
  logic [NW-1:0]      addr_ext;
  logic [PW-1:0]      addr_pw;
  logic [NW-1:0]      node_inc;
  logic [NW-1:0]      nb_inc;
  logic [NW-1:0]      nb_ext;
  logic [PA-1:0]      ptr_raddr;
  logic [NZ_AW-1:0]   row_a_addr;
  logic [PW-1:0]      bound_base;
  logic [PW-1:0]      bound_c;
  logic [PW-1:0]      bound_hi;
  logic [SW-1:0]      ends;
  logic [SW-1:0]      centre;
  logic [SW-1:0]      tri_half;
  grfe_out_t          result;

  assign cfg_ready = 1'b1;
  assign active    = (NW'(node_count_r) < NW'(MAX_NODES)) ? NW'(node_count_r)
                                                          : NW'(MAX_NODES);
  assign addr_ext  = NW'(in_data.address);
  assign addr_pw   = PW'(in_data.address);
  assign node_inc  = node_r + NW'(1);
  assign nb_ext    = NW'(row_a_r);
  assign nb_inc    = NW'(nb_r) + NW'(1);

  assign status.query_bad  = addr_ext >= active;
  assign status.own_done   = p_r >= hi_r;
  assign status.nb_out     = nb_ext >= active;
  assign status.merge_done = (q_r >= nhi_r) || (x_r >= hi_r);

  always_comb begin
    ptr_raddr = node_r[PA-1:0];
    case (cmd)
      CMD_OWN_HI_RD: ptr_raddr = node_inc[PA-1:0];
      CMD_NB_LO_RD:  ptr_raddr = nb_ext[PA-1:0];
      CMD_NB_HI_RD:  ptr_raddr = nb_inc[PA-1:0];
      default:       ptr_raddr = node_r[PA-1:0];
    endcase
  end

  assign row_a_addr = (cmd == CMD_MERGE_RD) ? q_r[NZ_AW-1:0] : p_r[NZ_AW-1:0];

  // end bound of a list, empty when it lies below the start
  assign bound_base = (cmd == CMD_NB_SET) ? nlo_r : lo_r;
  assign bound_c    = clamp_ptr(ptr_rd_r);
  assign bound_hi   = (bound_c < bound_base) ? bound_base : bound_c;

  always_ff @(posedge clk) begin
    if (cmd == CMD_ACCEPT && in_data.action == ACT_WR_PTR &&
        addr_ext <= NW'(MAX_NODES)) begin
      ptr_mem[addr_ext[PA-1:0]] <= PTR_W'(in_data.value);
    end
    ptr_rd_r <= ptr_mem[ptr_raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd == CMD_ACCEPT && in_data.action == ACT_WR_ROW &&
        addr_pw < PW'(MAX_NONZEROS)) begin
      row_mem[addr_pw[NZ_AW-1:0]] <= in_data.value[ROW_W-1:0];
    end
    row_a_r <= row_mem[row_a_addr];
    row_b_r <= row_mem[x_r[NZ_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= NODE_COUNT_RST;
    end else if (cfg_valid && cfg_ready) begin
      node_count_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd)
      CMD_ACCEPT: begin
        node_r <= addr_ext;
        bad_r  <= status.query_bad;
      end
      CMD_OWN_HI_RD: lo_r <= clamp_ptr(ptr_rd_r);
      CMD_OWN_SET: begin
        hi_r   <= bound_hi;
        deg_r  <= bound_hi - lo_r;
        p_r    <= lo_r;
        nsum_r <= '0;
        tri_r  <= '0;
      end
      CMD_NB_LO_RD: nb_r <= row_a_r;
      CMD_NB_HI_RD: nlo_r <= clamp_ptr(ptr_rd_r);
      CMD_NB_SET: begin
        nhi_r  <= bound_hi;
        nsum_r <= nsum_r + SW'(bound_hi - nlo_r);
        q_r    <= nlo_r;
        x_r    <= lo_r;
      end
      CMD_NEXT_NB: p_r <= p_r + PW'(1);
      CMD_MERGE_STEP: begin
        // row_a_r is the neighbour's entry, row_b_r the node's own
        if (row_a_r < row_b_r) begin
          q_r <= q_r + PW'(1);
        end else if (row_a_r == row_b_r) begin
          tri_r <= tri_r + SW'(1);
          q_r   <= q_r + PW'(1);
          x_r   <= x_r + PW'(1);
        end else begin
          x_r <= x_r + PW'(1);
        end
      end
      CMD_CENTRE: prod_r <= SW'(deg_r) * SW'(deg_r - PW'(1));
      CMD_OUTPUT: out_r <= result;
      default: ;
    endcase
  end

  assign ends     = (nsum_r >= SW'(deg_r)) ? nsum_r - SW'(deg_r) : '0;
  assign centre   = prod_r >> 1;
  assign tri_half = tri_r >> 1;

  always_comb begin
    result.node = node_r[NODE_W-1:0];
    if (bad_r) begin
      result.degree          = '0;
      result.paths_as_end    = '0;
      result.paths_as_centre = '0;
      result.triangles       = '0;
      result.bad_query       = 1'b1;
    end else begin
      result.degree = (deg_r > PW'({DEG_W{1'b1}})) ? {DEG_W{1'b1}} : deg_r[DEG_W-1:0];
      result.paths_as_end = (ends > SW'({END_W{1'b1}})) ? {END_W{1'b1}}
                                                        : ends[END_W-1:0];
      result.paths_as_centre = (centre > SW'({CENTRE_W{1'b1}})) ? {CENTRE_W{1'b1}}
                                                                : centre[CENTRE_W-1:0];
      result.triangles = (tri_half > SW'({TRI_W{1'b1}})) ? {TRI_W{1'b1}}
                                                         : tri_half[TRI_W-1:0];
      result.bad_query = 1'b0;
    end
  end

  assign out_data = out_r;

endmodule

@@ rtl/core/grfe_ctrl.sv @@
`timescale 1ns / 1ps

module grfe_ctrl (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [grfe_pkg::ACTION_W-1:0]   in_action,
  output logic                            busy,
  input  grfe_pkg::grfe_status_t          status,
  output grfe_pkg::grfe_cmd_t             cmd,
  output logic                            out_valid
);
  import grfe_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_OWN_A,
    S_OWN_B,
    S_OWN_C,
    S_ROW_RD,
    S_NB_A,
    S_NB_B,
    S_NB_C,
    S_MERGE_RD,
    S_MERGE_CMP,
    S_CENTRE,
    S_DONE
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;

  assign busy      = state_r != S_IDLE;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = CMD_NONE;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd = CMD_ACCEPT;
          if (in_action == ACT_QUERY) begin
            state_nxt = status.query_bad ? S_DONE : S_OWN_A;
          end
        end
      end
      S_OWN_A: begin
        cmd       = CMD_OWN_LO_RD;
        state_nxt = S_OWN_B;
      end
      S_OWN_B: begin
        cmd       = CMD_OWN_HI_RD;
        state_nxt = S_OWN_C;
      end
      S_OWN_C: begin
        cmd       = CMD_OWN_SET;
        state_nxt = S_ROW_RD;
      end
      S_ROW_RD: begin
        if (status.own_done) begin
          cmd       = CMD_CENTRE;
          state_nxt = S_DONE;
        end else begin
          cmd       = CMD_ROW_RD;
          state_nxt = S_NB_A;
        end
      end
      S_NB_A: begin
        // a neighbour past the node count has an empty list
        if (status.nb_out) begin
          cmd       = CMD_NEXT_NB;
          state_nxt = S_ROW_RD;
        end else begin
          cmd       = CMD_NB_LO_RD;
          state_nxt = S_NB_B;
        end
      end
      S_NB_B: begin
        cmd       = CMD_NB_HI_RD;
        state_nxt = S_NB_C;
      end
      S_NB_C: begin
        cmd       = CMD_NB_SET;
        state_nxt = S_MERGE_RD;
      end
      S_MERGE_RD: begin
        if (status.merge_done) begin
          cmd       = CMD_NEXT_NB;
          state_nxt = S_ROW_RD;
        end else begin
          cmd       = CMD_MERGE_RD;
          state_nxt = S_MERGE_CMP;
        end
      end
      S_MERGE_CMP: begin
        cmd       = CMD_MERGE_STEP;
        state_nxt = S_MERGE_RD;
      end
      S_CENTRE: begin
        cmd       = CMD_CENTRE;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        cmd       = CMD_OUTPUT;
        state_nxt = S_IDLE;
      end
      default: begin
        cmd       = CMD_NONE;
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= state_r == S_DONE;
    end
  end

  a_strobe_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r == S_DONE))
    else $error("result strobe without a finished query");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe held for two cycles");

  a_query_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_action == ACT_QUERY) |=> busy)
    else $error("accepted query did not start work");

  a_write_stays_free: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_action != ACT_QUERY) |=> !busy && !out_valid_r)
    else $error("store write blocked the block or made a result");

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import grfe_pkg::*;

  localparam int NODE_LIMIT  = MAX_NODES_DEF;
  localparam int NNZ_LIMIT   = MAX_NONZEROS_DEF;
  localparam int CYCLE_LIMIT = 4000000;
  localparam logic [ACTION_W-1:0] ACT_IGNORED = 2'd3;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 start     = 1'b0;
  logic                 busy;
  grfe_in_t             in_data   = '0;
  logic                 out_valid;
  grfe_out_t            out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [COUNT_W-1:0]   cfg_data  = '0;

  // shadow copy of the graph and the node count register
  bit [PTR_W-1:0]   ptr_mirror [0:NODE_LIMIT];
  bit [ROW_W-1:0]   row_mirror [0:NNZ_LIMIT-1];
  bit [COUNT_W-1:0] count_mirror = NODE_COUNT_RST;

  grfe_out_t   pending_freqs [$];
  int          error_count = 0;
  int          gap_pct     = 0;
  int          beats_taken = 0;
  int unsigned graph_nnz   = 0;
  longint      cycle_count = 0;
  int          gap_phase [3] = '{0, 54, 12};

  // graph under construction
  bit          adj_mat [0:NODE_LIMIT-1][0:NODE_LIMIT-1];
  int unsigned deg_gen [0:NODE_LIMIT-1];

  always #1 clk = ~clk;

  graphlet_raw_frequency_engine #(
    .MAX_NODES(NODE_LIMIT),
    .MAX_NONZEROS(NNZ_LIMIT)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  function automatic int unsigned active_limit();
    return (count_mirror < NODE_LIMIT) ? count_mirror : NODE_LIMIT;
  endfunction

  function automatic longint unsigned clip(input longint unsigned v, input int w);
    longint unsigned top;
    top = (64'd1 << w) - 1;
    return (v > top) ? top : v;
  endfunction

  function automatic void list_span(input int unsigned k, output int unsigned lo,
                                    output int unsigned hi);
    int unsigned a, b;
    if (k >= active_limit()) begin
      lo = 0;
      hi = 0;
    end else begin
      a = ptr_mirror[k];
      b = ptr_mirror[k + 1];
      if (a > NNZ_LIMIT) a = NNZ_LIMIT;
      if (b > NNZ_LIMIT) b = NNZ_LIMIT;
      if (b < a) b = a;
      lo = a;
      hi = b;
    end
  endfunction

  function automatic grfe_out_t predict_frequencies(input int unsigned addr);
    grfe_out_t         res;
    int unsigned       lo, hi, nlo, nhi, p, q, l, x, deg, rv, own;
    longint unsigned   nsum, tri_sum, ends, centre;
    bit                stop;
    res = '0;
    res.node = addr[NODE_W-1:0];
    if (addr >= active_limit()) begin
      res.bad_query = 1'b1;
      return res;
    end
    nsum = 0;
    tri_sum = 0;
    list_span(addr, lo, hi);
    deg = hi - lo;
    for (p = lo; p < hi; p++) begin
      list_span(row_mirror[p], nlo, nhi);
      nsum += nhi - nlo;
      // merge the neighbour list against the node's own list
      x = lo;
      for (q = nlo; q < nhi; q++) begin
        rv = row_mirror[q];
        l = x;
        stop = 1'b0;
        while (!stop && l < hi) begin
          own = row_mirror[l];
          if (rv < own) begin
            x = l;
            stop = 1'b1;
          end else if (rv == own) begin
            tri_sum++;
            x = l + 1;
            stop = 1'b1;
          end else begin
            x = l + 1;
            l++;
          end
        end
      end
    end
    ends = (nsum >= deg) ? nsum - deg : 0;
    centre = (deg != 0) ? (longint'(deg) * longint'(deg - 1)) / 2 : 0;
    res.degree          = DEG_W'(clip(deg, DEG_W));
    res.paths_as_end    = END_W'(clip(ends, END_W));
    res.paths_as_centre = CENTRE_W'(clip(centre, CENTRE_W));
    res.triangles       = TRI_W'(clip(tri_sum / 2, TRI_W));
    return res;
  endfunction

  // one item beat; returns at the falling edge after acceptance with start still high
  task automatic send_beat(input logic [ACTION_W-1:0] act, input int unsigned addr,
                           input int unsigned val);
    grfe_in_t beat;
    beat.action  = act;
    beat.address = addr[ADDR_W-1:0];
    beat.value   = val[VALUE_W-1:0];
    while ($urandom_range(0, 99) < gap_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    in_data <= beat;
    start   <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    case (act)
      ACT_WR_PTR: begin
        if (beat.address <= NODE_LIMIT) begin
          ptr_mirror[beat.address] = beat.value;
          beats_taken++;
        end
      end
      ACT_WR_ROW: begin
        if (beat.address < NNZ_LIMIT) begin
          row_mirror[beat.address] = beat.value[ROW_W-1:0];
          beats_taken++;
        end
      end
      ACT_QUERY: begin
        pending_freqs.push_back(predict_frequencies(beat.address));
        beats_taken++;
      end
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (pending_freqs.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_node_count(input int unsigned cnt);
    drain_results();
    cfg_data  <= cnt[COUNT_W-1:0];
    cfg_valid <= 1'b1;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    count_mirror = cnt[COUNT_W-1:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic clear_graph(input int unsigned n);
    for (int i = 0; i < n; i++) begin
      deg_gen[i] = 0;
      for (int j = 0; j < n; j++) adj_mat[i][j] = 1'b0;
    end
  endtask

  task automatic add_edge(input int unsigned i, input int unsigned j);
    if (i != j && !adj_mat[i][j]) begin
      adj_mat[i][j] = 1'b1;
      adj_mat[j][i] = 1'b1;
      deg_gen[i]++;
      deg_gen[j]++;
    end
  endtask

  task automatic random_edges(input int unsigned n, input int unsigned maxdeg,
                              input int unsigned tries);
    int unsigned i, j;
    repeat (tries) begin
      i = $urandom_range(0, n - 1);
      j = $urandom_range(0, n - 1);
      if (deg_gen[i] < maxdeg && deg_gen[j] < maxdeg) add_edge(i, j);
    end
  endtask

  // beats the graph must shrug off: unknown action, pointer slot past the end,
  // row write beyond the loaded lists
  task automatic send_filler();
    case ($urandom_range(0, 2))
      0: send_beat(ACT_IGNORED, $urandom_range(0, 8191), $urandom_range(0, 16383));
      1: send_beat(ACT_WR_PTR, $urandom_range(NODE_LIMIT + 1, 8191),
                   $urandom_range(0, 16383));
      default: send_beat(ACT_WR_ROW, $urandom_range(graph_nnz, NNZ_LIMIT - 1),
                         $urandom_range(0, 16383));
    endcase
  endtask

  task automatic emit_graph(input int unsigned n, input int noise_pct);
    int unsigned pos;
    graph_nnz = 0;
    for (int i = 0; i < n; i++) graph_nnz += deg_gen[i];
    pos = 0;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < noise_pct) send_filler();
      send_beat(ACT_WR_PTR, i, pos);
      for (int j = 0; j < n; j++) begin
        if (adj_mat[i][j]) begin
          if ($urandom_range(0, 99) < noise_pct) send_filler();
          // upper value bits are dropped by the row store
          send_beat(ACT_WR_ROW, pos, j | ($urandom_range(0, 15) << ROW_W));
          pos++;
        end
      end
    end
    send_beat(ACT_WR_PTR, n, pos);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin : check_results
    grfe_out_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (pending_freqs.size() == 0) begin
        $display("%0t: result beat with nothing expected, expected none, actual %h",
                 $time, out_data);
        error_count++;
      end else begin
        want = pending_freqs.pop_front();
        check_field("node", want.node, out_data.node);
        check_field("degree", want.degree, out_data.degree);
        check_field("paths_as_end", want.paths_as_end, out_data.paths_as_end);
        check_field("paths_as_centre", want.paths_as_centre, out_data.paths_as_centre);
        check_field("triangles", want.triangles, out_data.triangles);
        check_field("bad_query", want.bad_query, out_data.bad_query);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // every store entry gets written once so no query ever reads an unset slot
  task automatic test_preload_stores();
    gap_pct = 0;
    for (int i = 0; i <= NODE_LIMIT; i++) send_beat(ACT_WR_PTR, i, 0);
    for (int i = 0; i < NNZ_LIMIT; i++) send_beat(ACT_WR_ROW, i, $urandom_range(0, 16383));
  endtask

  task automatic test_bad_queries();
    send_beat(ACT_QUERY, 0, 16383);
    send_beat(ACT_QUERY, 1, 0);
    send_beat(ACT_QUERY, 8191, 16383);
    set_node_count(0);
    send_beat(ACT_QUERY, 0, 0);
    send_beat(ACT_QUERY, 5, 8192);
  endtask

  task automatic test_triangle_graph();
    clear_graph(5);
    add_edge(0, 1);
    add_edge(0, 2);
    add_edge(1, 2);
    add_edge(2, 3);
    set_node_count(5);
    emit_graph(5, 0);
    for (int i = 0; i < 5; i++) send_beat(ACT_QUERY, i, 16383);
    send_beat(ACT_QUERY, 4095, 0);
  endtask

  task automatic test_ignored_items();
    send_beat(ACT_IGNORED, 8191, 16383);
    send_beat(ACT_IGNORED, 0, 0);
    send_beat(ACT_WR_PTR, NODE_LIMIT + 1, 16383);
    send_beat(ACT_WR_PTR, 8191, 0);
    send_beat(ACT_WR_ROW, graph_nnz, 16383);
    send_beat(ACT_QUERY, 2, 0);
  endtask

  // start pointer clipped at the row store end, end pointer below start,
  // neighbours past the node count
  task automatic test_broken_lists();
    set_node_count(2);
    send_beat(ACT_WR_PTR, 0, 8190);
    send_beat(ACT_WR_PTR, 1, 16383);
    send_beat(ACT_WR_PTR, 2, 5);
    send_beat(ACT_WR_ROW, 8190, 1000);
    send_beat(ACT_WR_ROW, 8191, 1);
    send_beat(ACT_QUERY, 0, 0);
    send_beat(ACT_QUERY, 1, 0);
  endtask

  task automatic test_saturation();
    // long list of out-of-range neighbours saturates degree and centre paths
    set_node_count(2);
    send_beat(ACT_WR_PTR, 0, 0);
    send_beat(ACT_WR_PTR, 1, 1100);
    send_beat(ACT_WR_PTR, 2, 1100);
    for (int i = 0; i < 1100; i++) send_beat(ACT_WR_ROW, i, 1000);
    send_beat(ACT_QUERY, 0, 0);
    // three links to one heavy node saturate the end paths
    set_node_count(3);
    send_beat(ACT_WR_PTR, 0, 0);
    send_beat(ACT_WR_PTR, 1, 3);
    send_beat(ACT_WR_PTR, 2, 6003);
    send_beat(ACT_WR_PTR, 3, 6003);
    for (int i = 0; i < 3; i++) send_beat(ACT_WR_ROW, i, 1);
    for (int i = 3; i < 6003; i++) send_beat(ACT_WR_ROW, i, 2000);
    send_beat(ACT_QUERY, 0, 0);
    send_beat(ACT_QUERY, 1, 0);
    send_beat(ACT_QUERY, 2, 0);
  endtask

  task automatic test_dense_clique();
    clear_graph(20);
    for (int i = 0; i < 20; i++)
      for (int j = i + 1; j < 20; j++) add_edge(i, j);
    set_node_count(20);
    emit_graph(20, 0);
    send_beat(ACT_QUERY, 0, 0);
    send_beat(ACT_QUERY, 19, 0);
    repeat (3) send_beat(ACT_QUERY, $urandom_range(1, 18), 0);
  endtask

  task automatic test_full_count();
    clear_graph(NODE_LIMIT);
    random_edges(NODE_LIMIT, 3, 3000);
    set_node_count(2047);
    emit_graph(NODE_LIMIT, 2);
    send_beat(ACT_QUERY, 0, 0);
    send_beat(ACT_QUERY, NODE_LIMIT - 1, 0);
    repeat (3) send_beat(ACT_QUERY, $urandom_range(0, NODE_LIMIT - 1), 0);
    send_beat(ACT_QUERY, NODE_LIMIT, 0);
    send_beat(ACT_QUERY, 2047, 0);
    send_beat(ACT_QUERY, 8191, 0);
    set_node_count(NODE_LIMIT);
    send_beat(ACT_QUERY, NODE_LIMIT - 1, 0);
    send_beat(ACT_QUERY, NODE_LIMIT, 0);
  endtask

  task automatic run_round(input int round);
    int unsigned n, cnt, maxdeg, nq, pick, addr;
    n = ($urandom_range(0, 19) == 0) ? 1 : $urandom_range(2, 48);
    maxdeg = $urandom_range(1, 8);
    cnt = ($urandom_range(0, 4) == 0) ? $urandom_range(1, n) : n;
    clear_graph(n);
    random_edges(n, maxdeg, n * maxdeg);
    set_node_count(cnt);
    gap_pct = gap_phase[round % 3];
    emit_graph(n, 8);
    nq = $urandom_range(8, 30);
    repeat (nq) begin
      pick = $urandom_range(0, 99);
      if (pick < 5 && graph_nnz > 0) begin
        // scramble one list entry; lists may lose their order or gain a self loop
        send_beat(ACT_WR_ROW, $urandom_range(0, graph_nnz - 1),
                  $urandom_range(0, cnt - 1) | ($urandom_range(0, 15) << ROW_W));
      end else begin
        if (pick < 85) addr = $urandom_range(0, cnt - 1);
        else if (pick < 93) addr = $urandom_range(cnt, 2047);
        else addr = $urandom_range(0, 8191);
        send_beat(ACT_QUERY, addr, $urandom_range(0, 16383));
      end
    end
  endtask

  task automatic test_random_traffic();
    int first_beat;
    int round;
    first_beat = beats_taken;
    round = 0;
    while (beats_taken - first_beat < 2000) begin
      run_round(round);
      round++;
    end
    gap_pct = 0;
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_preload_stores();
    test_bad_queries();
    test_triangle_graph();
    test_ignored_items();
    test_broken_lists();
    test_saturation();
    test_dense_clique();
    test_full_count();
    test_random_traffic();
    drain_results();
    repeat (20) @(negedge clk);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
